// ===== src/bst_pkg.sv =====
package bst_pkg;

    localparam int DEPTH   = 128;
    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int VALUE_W = 32;
    localparam int POS_W   = 7;
    localparam int COUNT_W = 8;
    localparam int CAP_W   = 8;

    // widths that hold both the internal index/count and the port field
    localparam int POS_EXT = (CW > POS_W) ? CW : POS_W;
    localparam int CNT_EXT = (CW > COUNT_W) ? CW : COUNT_W;
    localparam int CMP_W   = (CW > CAP_W) ? CW : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 8'd100;

    typedef logic [1:0]                t_opcode;
    typedef logic signed [VALUE_W-1:0] t_value;
    typedef logic [AW-1:0]             t_idx;
    typedef logic [CW-1:0]             t_cnt;

    localparam t_opcode OP_SEARCH = 2'd0;
    localparam t_opcode OP_ADD    = 2'd1;
    localparam t_opcode OP_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_PRESENT   = 2'd2,
        ST_FULL      = 2'd3
    } t_status;

endpackage

// ===== src/bst_if.sv =====
interface bst_in_if;
    logic             valid;
    logic             ready;
    bst_pkg::t_opcode opcode;
    bst_pkg::t_value  value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink (input valid, input opcode, input value, output ready);
endinterface

interface bst_out_if;
    logic                             valid;
    logic                             ready;
    bst_pkg::t_status                 status;
    logic [bst_pkg::POS_W-1:0]        position;
    logic [bst_pkg::COUNT_W-1:0]      count;

    modport source (output valid, output status, output position, output count,
                    input ready);
    modport sink (input valid, input status, input position, input count,
                  output ready);
endinterface

interface bst_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bst_pkg::CAP_W-1:0]   data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/bst_ram.sv =====
module bst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// ===== src/bounded_set_table_core.sv =====
// Bounded set table: a set of distinct signed 32-bit values held in an
// ordered table of DEPTH entries plus an entry count.
//
// Channels (valid/ready, a word moves when both are high):
//   i_in   - opcode (search, add, delete; the spare code acts as search) and value
//   o_out  - status, position and the entry count after the operation
//   i_cfg  - capacity register; write it only while the block is idle
//
// Each word is handled alone: the table RAM is scanned one entry per cycle
// through its registered read port, until a hit or the end of the count. A
// delete that hits then moves each later entry down one per cycle after its
// scan stops. The result word shows up in the same cycle as the block turns
// ready again; i_in.ready is high only while idle.
//
// A finished result sits in the output register; the next word is accepted
// while it waits. If the receiver stalls, the following result holds in the
// sequencer until the register frees up.
// Reset empties the set (count 0) and loads capacity 100; the RAM contents are
// not cleared, since only entries below the count are ever read.
module bounded_set_table_core (
    input logic       i_clk,
    input logic       i_rst_n,
    bst_in_if.sink    i_in,
    bst_out_if.source o_out,
    bst_cfg_if.sink   i_cfg
);

    import bst_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_RESOLVE = 5'b00100,
        S_SHIFT   = 5'b01000,
        S_EMIT    = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CAP_W-1:0]    r_capacity;
    t_cnt                r_count, n_count;
    t_opcode             r_op;
    t_value              r_value;
    t_cnt                r_addr, n_addr;       // next RAM read address
    t_cnt                r_cmp_idx, n_cmp_idx; // index of the word in flight
    logic                r_pend, n_pend;       // a read is in flight
    logic                r_hit, n_hit;
    t_cnt                r_pos, n_pos;
    t_status             r_status, n_status;

    logic                r_out_valid, n_out_valid;
    t_status             r_out_status, n_out_status;
    logic [POS_W-1:0]    r_out_pos, n_out_pos;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;

    logic                w_wr_en;
    t_idx                w_wr_addr;
    logic [VALUE_W-1:0]  w_wr_data;
    t_idx                w_rd_addr;
    logic [VALUE_W-1:0]  w_rd_data;
    logic                w_match;
    logic                w_full;
    logic [POS_EXT-1:0]  w_pos_ext;
    logic [CNT_EXT-1:0]  w_cnt_ext;

    bst_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // The read port always follows the scan address; a read past the count is
    // simply never looked at.
    assign w_rd_addr = r_addr[AW-1:0];
    assign w_match   = r_pend && (w_rd_data == r_value);

    // Effective capacity is min(capacity, DEPTH).
    assign w_full = (CMP_W'(r_count) >= CMP_W'(r_capacity)) || (r_count == CW'(DEPTH));

    assign w_pos_ext = POS_EXT'(r_pos);
    assign w_cnt_ext = CNT_EXT'(n_count);

    assign i_in.ready     = (r_state == S_IDLE);
    assign i_cfg.ready    = 1'b1;
    assign o_out.valid    = r_out_valid;
    assign o_out.status   = r_out_status;
    assign o_out.position = r_out_pos;
    assign o_out.count    = r_out_count;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_addr       = r_addr;
        n_cmp_idx    = r_cmp_idx;
        n_pend       = r_pend;
        n_hit        = r_hit;
        n_pos        = r_pos;
        n_status     = r_status;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_count  = r_out_count;
        w_wr_en      = 1'b0;
        w_wr_addr    = r_count[AW-1:0];
        w_wr_data    = r_value;

        // drop the result once the receiver takes it
        if (r_out_valid && o_out.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_addr  = '0;
                    n_pend  = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // compare the word read last cycle, issue the next read
                if (w_match) begin
                    n_hit   = 1'b1;
                    n_pos   = r_cmp_idx;
                    n_pend  = 1'b0;
                    n_state = S_RESOLVE;
                end else if (r_addr < r_count) begin
                    n_cmp_idx = r_addr;
                    n_pend    = 1'b1;
                    n_addr    = r_addr + 1'b1;
                end else begin
                    n_hit   = 1'b0;
                    n_pend  = 1'b0;
                    n_state = S_RESOLVE;
                end
            end
            S_RESOLVE: begin
                n_state = S_EMIT;
                priority if (r_op == OP_ADD) begin
                    priority if (r_hit) begin
                        n_status = ST_PRESENT;
                    end else if (w_full) begin
                        n_status = ST_FULL;
                        n_pos    = '0;
                    end else begin
                        w_wr_en  = 1'b1;
                        n_pos    = r_count;
                        n_count  = r_count + 1'b1;
                        n_status = ST_OK;
                    end
                end else if (r_op == OP_DELETE) begin
                    if (r_hit) begin
                        n_status = ST_OK;
                        n_addr   = r_pos + 1'b1;
                        n_pend   = 1'b0;
                        n_state  = S_SHIFT;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_pos    = '0;
                    end
                end else begin
                    if (r_hit) begin
                        n_status = ST_OK;
                    end else begin
                        n_status = ST_NOT_FOUND;
                        n_pos    = '0;
                    end
                end
            end
            S_SHIFT: begin
                // move each later entry down one place: read j+1, write j
                if (r_pend) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_cmp_idx[AW-1:0];
                    w_wr_data = w_rd_data;
                end
                if (r_addr < r_count) begin
                    n_cmp_idx = r_addr - 1'b1;
                    n_pend    = 1'b1;
                    n_addr    = r_addr + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_pos    = w_pos_ext[POS_W-1:0];
                    n_out_count  = w_cnt_ext[COUNT_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_capacity  <= CAP_RESET;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_capacity <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_op    <= i_in.opcode;
            r_value <= i_in.value;
        end
        r_addr       <= n_addr;
        r_cmp_idx    <= n_cmp_idx;
        r_hit        <= n_hit;
        r_pos        <= n_pos;
        r_status     <= n_status;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_count  <= n_out_count;
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count exceeds table depth");

    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> (r_state == S_SCAN))
        else $error("accepted word did not start a scan");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_SCAN || r_state == S_EMIT)
        |=> $stable(r_count))
        else $error("entry count changed outside add or delete");

    a_write_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_wr_en |-> (r_state == S_RESOLVE || r_state == S_SHIFT))
        else $error("table write outside add or shift");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_pend) |-> (r_cmp_idx < r_count))
        else $error("scan compared an entry beyond the count");
`endif

endmodule

// ===== bench/bst_result_checker.sv =====
`timescale 1ns / 1ps

module bst_result_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    bst_in_if    i_in,
    bst_out_if   i_out,
    bst_cfg_if   i_cfg,
    output int   o_fail_count,
    output int   o_pending
);

    import bst_pkg::*;

    typedef struct packed {
        t_status            status;
        logic [POS_W-1:0]   position;
        logic [COUNT_W-1:0] count;
    } t_table_reply;

    t_value           members [DEPTH];
    int               member_count;
    logic [CAP_W-1:0] capacity_reg;
    t_table_reply     replies_due [$];
    t_table_reply     head;
    int               mismatch_total = 0;

    task automatic flag_mismatch(string what);
        mismatch_total++;
        if (mismatch_total <= 200)
            $display("%0t set check: %s", $time, what);
    endtask

    // Apply one operation to the shadow table and return the reply it owes.
    function automatic t_table_reply apply_set_op(t_opcode op, t_value v);
        t_table_reply r;
        int           i;
        int           hit_at;
        int           cap_eff;
        hit_at  = -1;
        cap_eff = (int'(capacity_reg) < DEPTH) ? int'(capacity_reg) : DEPTH;
        for (i = member_count - 1; i >= 0; i--)
            if (members[i] == v)
                hit_at = i;
        r.status   = ST_NOT_FOUND;
        r.position = '0;
        case (op)
            OP_ADD: begin
                if (hit_at >= 0) begin
                    r.status   = ST_PRESENT;
                    r.position = POS_W'(hit_at);
                end else if (member_count >= cap_eff) begin
                    r.status = ST_FULL;
                end else begin
                    members[member_count] = v;
                    r.position = POS_W'(member_count);
                    r.status   = ST_OK;
                    member_count++;
                end
            end
            OP_DELETE: begin
                if (hit_at >= 0) begin
                    for (i = hit_at; i < member_count - 1; i++)
                        members[i] = members[i + 1];
                    member_count--;
                    r.status   = ST_OK;
                    r.position = POS_W'(hit_at);
                end
            end
            default: begin
                if (hit_at >= 0) begin
                    r.status   = ST_OK;
                    r.position = POS_W'(hit_at);
                end
            end
        endcase
        r.count = COUNT_W'(member_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            member_count = 0;
            capacity_reg = CAP_RESET;
            replies_due.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready)
                capacity_reg = i_cfg.data;
            if (i_in.valid && i_in.ready)
                replies_due.push_back(apply_set_op(i_in.opcode, i_in.value));
            if (i_out.valid && i_out.ready) begin
                if (replies_due.size() == 0) begin
                    flag_mismatch("result word with nothing outstanding");
                end else begin
                    head = replies_due.pop_front();
                    if (i_out.status !== head.status)
                        flag_mismatch($sformatf("status %0d, want %0d",
                                                i_out.status, head.status));
                    if (i_out.position !== head.position)
                        flag_mismatch($sformatf("position %0d, want %0d",
                                                i_out.position, head.position));
                    if (i_out.count !== head.count)
                        flag_mismatch($sformatf("count %0d, want %0d",
                                                i_out.count, head.count));
                end
            end
        end
        o_pending    <= replies_due.size();
        o_fail_count <= mismatch_total;
    end

endmodule

// ===== bench/bounded_set_table_core_tb.sv =====
`timescale 1ns / 1ps

module bounded_set_table_core_tb;
    import bst_pkg::*;

    // spare opcode, handled by the block as a search
    localparam t_opcode OP_SPARE = 2'd3;

    // receiver stall styles
    localparam int RX_STEADY  = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    logic clk;
    logic rst_n;

    bst_in_if  in_ch ();
    bst_out_if out_ch ();
    bst_cfg_if cfg_ch ();

    int fail_count;
    int pending;

    // sender and receiver behavior, changed between phases
    int     burst_left   = 0;
    bit     tx_gappy     = 1'b0;
    int     rx_mode      = RX_STEADY;
    int     hold_request = 0;
    t_value value_pool [256];

    bounded_set_table_core dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    bst_result_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_cfg        (cfg_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one word and hold it until the block takes it. In gappy mode the
    // words come in bursts; drop valid for a random gap between bursts.
    task automatic send_word(t_opcode op, t_value v);
        int gap;
        if (tx_gappy && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                              : $urandom_range(0, 6);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_ch.valid  <= 1'b1;
        in_ch.opcode <= op;
        in_ch.value  <= v;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Drop valid and hold until every outstanding result word has come back,
    // then let the block sit idle for the given tail.
    task automatic wait_idle(int tail);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (tail) @(posedge clk);
    endtask

    // Only call with the block idle.
    task automatic write_capacity(logic [CAP_W-1:0] cap);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= cap;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Random traffic. Values mostly come from the first pool_len pool entries,
    // so adds fill the table and searches and deletes hit; the rest are fully
    // random and almost always miss.
    task automatic run_phase(int words, int pool_len, int add_pct, int del_pct,
                             bit gappy, int rx);
        int      n;
        int      roll;
        t_opcode op;
        t_value  v;
        tx_gappy   = gappy;
        rx_mode    = rx;
        burst_left = 0;
        for (n = 0; n < words; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < add_pct)
                op = OP_ADD;
            else if (roll < add_pct + del_pct)
                op = OP_DELETE;
            else if ($urandom_range(0, 19) == 0)
                op = OP_SPARE;
            else
                op = OP_SEARCH;
            if ($urandom_range(0, 9) == 0)
                v = t_value'($urandom);
            else
                v = value_pool[$urandom_range(0, pool_len - 1)];
            send_word(op, v);
        end
    endtask

    // Receiver: a long hold-off when one is requested, otherwise stall in the
    // style the current phase picks.
    initial begin
        int stall_left;
        int tick;
        stall_left = 0;
        tick       = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            tick++;
            if (hold_request > 0) begin
                stall_left   = hold_request;
                hold_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_STEADY: begin
                        out_ch.ready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        if ($urandom_range(0, 3) == 0) begin
                            stall_left = $urandom_range(0, 7);
                            out_ch.ready <= 1'b0;
                        end else begin
                            out_ch.ready <= 1'b1;
                        end
                    end
                    default: begin
                        out_ch.ready <= ((tick % 5) >= 2);
                    end
                endcase
            end
        end
    end

    // Stimulus and verdict.
    initial begin
        int i;
        rst_n        <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.opcode <= OP_SEARCH;
        in_ch.value  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;

        // Seed the pool with the value extremes, then random words.
        value_pool[0] = 32'sh8000_0000;
        value_pool[1] = 32'sh7FFF_FFFF;
        value_pool[2] = '0;
        value_pool[3] = '1;
        for (i = 4; i < 256; i++)
            value_pool[i] = t_value'($urandom);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part at the reset capacity of 100.
        // Search and delete on an empty table miss.
        send_word(OP_SEARCH, 32'sd5);
        send_word(OP_DELETE, 32'sd5);
        // Fill with the extremes, then re-add one that is already there.
        send_word(OP_ADD, 32'sh8000_0000);
        send_word(OP_ADD, 32'sh7FFF_FFFF);
        send_word(OP_ADD, 32'sd0);
        send_word(OP_ADD, -32'sd1);
        send_word(OP_ADD, 32'sh7FFF_FFFF);
        send_word(OP_SEARCH, -32'sd1);
        // The spare opcode searches and never changes the table.
        send_word(OP_SPARE, 32'sd0);
        send_word(OP_SPARE, 32'sd12345);
        // Delete from the middle, the head and the tail; later entries move down.
        send_word(OP_DELETE, 32'sh7FFF_FFFF);
        send_word(OP_SEARCH, -32'sd1);
        send_word(OP_DELETE, 32'sh8000_0000);
        send_word(OP_DELETE, -32'sd1);

        // Capacity of one with one entry: a new value is refused, but a
        // present value still reports as present.
        wait_idle(8);
        write_capacity(8'd1);
        send_word(OP_ADD, 32'sd77);
        send_word(OP_ADD, 32'sd0);

        // Capacity of zero refuses every add, even on an empty table.
        wait_idle(8);
        write_capacity(8'd0);
        send_word(OP_ADD, 32'sd9);
        send_word(OP_DELETE, 32'sd0);
        send_word(OP_ADD, 32'sd9);
        send_word(OP_SEARCH, 32'sd9);

        // Fill to the full depth. Start with a long receiver hold-off while the
        // sender keeps offering words, so the block backs up and stalls input.
        wait_idle(8);
        write_capacity(8'd128);
        hold_request = 300;
        run_phase(300, 160, 80, 5, 1'b0, RX_RANDOM);

        // Lower the capacity far below the count: adds refused until the
        // deletes drain the table.
        wait_idle(8);
        write_capacity(8'd3);
        run_phase(150, 160, 25, 45, 1'b1, RX_PATTERN);

        // Capacity above the depth acts as the depth.
        wait_idle(8);
        write_capacity(8'd255);
        run_phase(200, 40, 40, 40, 1'b1, RX_RANDOM);

        wait_idle(8);
        write_capacity(8'd1);
        run_phase(100, 8, 45, 30, 1'b1, RX_STEADY);

        wait_idle(8);
        write_capacity(8'd0);
        run_phase(100, 8, 40, 45, 1'b0, RX_PATTERN);

        // Back to the reset capacity, no idling on either side after another
        // long hold-off.
        wait_idle(8);
        write_capacity(8'd100);
        hold_request = 300;
        run_phase(200, 120, 60, 20, 1'b0, RX_STEADY);

        wait_idle(8);
        write_capacity(8'($urandom_range(2, 127)));
        run_phase(200, $urandom_range(4, 200), 45, 35, 1'b1, RX_RANDOM);

        wait_idle(8);
        write_capacity(8'd2);
        run_phase(100, 6, 40, 40, 1'b1, RX_RANDOM);

        // Drain, then give a stray result word time to show up.
        wait_idle(300);
        if (fail_count == 0 && pending == 0)
            $display("bounded_set_table_core_tb: clean");
        else
            $display("bounded_set_table_core_tb: errors");
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #15_000_000;
        $display("bounded_set_table_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/bst_pkg.sv
src/bst_if.sv
src/bst_ram.sv
src/bounded_set_table_core.sv
bench/bst_result_checker.sv
bench/bounded_set_table_core_tb.sv
